FILE: src/assert_macros.svh
// Assertion macros shared by the RTL. They expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: src/cdet_pkg.sv
package cdet_pkg;

  localparam int SelW    = 4;
  localparam int YearW   = 12;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinW    = 6;
  localparam int SecW    = 6;
  localparam int UptimeW = 64;
  localparam int WholeW  = 35;
  localparam int NanoW   = 30;
  localparam int MonthOffW = 25;

  localparam logic [SelW-1:0] ClkRealtime  = 4'd0;
  localparam logic [SelW-1:0] ClkMonotonic = 4'd1;

  localparam logic [WholeW-1:0] SecsCap  = 35'd18446744073;
  localparam logic [NanoW-1:0]  NsPerSec = 30'd1000000000;

  // Seconds in the months before the given one; month zero adds nothing and
  // months past December count as December.
  function automatic logic [MonthOffW-1:0] month_offset(input logic [MonthW-1:0] month,
                                                        input logic leap);
    logic [MonthOffW-1:0] base;
    case (month)
      4'd0, 4'd1: base = 25'd0;
      4'd2:       base = 25'd2678400;
      4'd3:       base = 25'd5097600;
      4'd4:       base = 25'd7776000;
      4'd5:       base = 25'd10368000;
      4'd6:       base = 25'd13046400;
      4'd7:       base = 25'd15638400;
      4'd8:       base = 25'd18316800;
      4'd9:       base = 25'd20995200;
      4'd10:      base = 25'd23587200;
      4'd11:      base = 25'd26265600;
      default:    base = 25'd28857600;
    endcase
    if (leap && (month >= 4'd3)) begin
      base = base + 25'd86400;
    end
    return base;
  endfunction

endpackage

FILE: src/calendar_date_to_epoch_time_top.sv
// Clock reading unit.
// A request is transferred at a rising clock edge where start is high and busy
// is low. It carries clock_select, the calendar fields and uptime_ns.
// Select zero turns the calendar date and time into whole seconds since 1970
// with zero nanoseconds. Select one splits uptime_ns into whole seconds and
// nanoseconds. Any other select gives status one with zero readings.
// Each answer is presented on whole_seconds, nanoseconds and status for
// exactly one cycle with done high and is taken at the edge that ends that
// cycle. The receiver cannot stall. Between a request and its answer lie
// the input register, the four multiply and add stages of the nanosecond
// split, which the calendar path matches, and the result register.
// A new request can be transferred in every cycle while busy is low, so
// throughput is one reading per clock.
// Reset clears all pending work and holds busy high during reset and until
// the first edge after it; no done strobe is produced for requests lost to reset.
`include "assert_macros.svh"

module calendar_date_to_epoch_time_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [cdet_pkg::SelW-1:0]       clock_select,
  input  logic [cdet_pkg::YearW-1:0]      cal_year,
  input  logic [cdet_pkg::MonthW-1:0]     cal_month,
  input  logic [cdet_pkg::DayW-1:0]       cal_day,
  input  logic [cdet_pkg::HourW-1:0]      cal_hour,
  input  logic [cdet_pkg::MinW-1:0]       cal_minute,
  input  logic [cdet_pkg::SecW-1:0]       cal_second,
  input  logic [cdet_pkg::UptimeW-1:0]    uptime_ns,
  output logic                            done,
  output logic [cdet_pkg::WholeW-1:0]     whole_seconds,
  output logic [cdet_pkg::NanoW-1:0]      nanoseconds,
  output logic                            status
);

  localparam int Depth = 4;

  logic accept;
  logic [Depth:0] vld;

  logic [cdet_pkg::SelW-1:0]    sel0;
  logic [cdet_pkg::YearW-1:0]   year0;
  logic [cdet_pkg::MonthW-1:0]  month0;
  logic [cdet_pkg::DayW-1:0]    day0;
  logic [cdet_pkg::HourW-1:0]   hour0;
  logic [cdet_pkg::MinW-1:0]    minute0;
  logic [cdet_pkg::SecW-1:0]    second0;
  logic [cdet_pkg::UptimeW-1:0] uptime0;

  logic [cdet_pkg::SelW-1:0] sel_d [Depth];

  logic [cdet_pkg::WholeW-1:0] rt_secs;
  logic [cdet_pkg::WholeW-1:0] mono_secs;
  logic [cdet_pkg::NanoW-1:0]  mono_ns;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[Depth-1:0], accept};
      done <= vld[Depth];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sel0    <= clock_select;
      year0   <= cal_year;
      month0  <= cal_month;
      day0    <= cal_day;
      hour0   <= cal_hour;
      minute0 <= cal_minute;
      second0 <= cal_second;
      uptime0 <= uptime_ns;
    end
  end

  always_ff @(posedge clk) begin
    sel_d[0] <= sel0;
    for (int i = 1; i < Depth; i++) begin
      sel_d[i] <= sel_d[i-1];
    end
  end

  cdet_rt_calc u_rt_calc (
    .clk           (clk),
    .cal_year      (year0),
    .cal_month     (month0),
    .cal_day       (day0),
    .cal_hour      (hour0),
    .cal_minute    (minute0),
    .cal_second    (second0),
    .whole_seconds (rt_secs)
  );

  cdet_ns_split u_ns_split (
    .clk           (clk),
    .uptime_ns     (uptime0),
    .whole_seconds (mono_secs),
    .nanoseconds   (mono_ns)
  );

  always_ff @(posedge clk) begin
    if (vld[Depth]) begin
      case (sel_d[Depth-1])
        cdet_pkg::ClkRealtime: begin
          whole_seconds <= rt_secs;
          nanoseconds   <= '0;
          status        <= 1'b0;
        end
        cdet_pkg::ClkMonotonic: begin
          whole_seconds <= mono_secs;
          nanoseconds   <= mono_ns;
          status        <= 1'b0;
        end
        default: begin
          whole_seconds <= '0;
          nanoseconds   <= '0;
          status        <= 1'b1;
        end
      endcase
    end
  end

  `ASSERT_IMPLY(a_done_latency, clk, rst, done, $past(accept, 6), "done without a request six cycles earlier")
  `ASSERT_IMPLY(a_invalid_zero, clk, rst, done && status, (whole_seconds == '0) && (nanoseconds == '0), "invalid reading with nonzero value")
  `ASSERT_IMPLY(a_ns_range, clk, rst, done, nanoseconds < cdet_pkg::NsPerSec, "nanoseconds out of range")
  `ASSERT_NEXT(a_busy_after_reset, clk, rst, $past(rst), !busy && !done, "busy or done one cycle past reset")

endmodule

FILE: src/cdet_rt_calc.sv
module cdet_rt_calc (
  input  logic                            clk,
  input  logic [cdet_pkg::YearW-1:0]      cal_year,
  input  logic [cdet_pkg::MonthW-1:0]     cal_month,
  input  logic [cdet_pkg::DayW-1:0]       cal_day,
  input  logic [cdet_pkg::HourW-1:0]      cal_hour,
  input  logic [cdet_pkg::MinW-1:0]       cal_minute,
  input  logic [cdet_pkg::SecW-1:0]       cal_second,
  output logic [cdet_pkg::WholeW-1:0]     whole_seconds
);

  localparam logic [11:0] EpochYear        = 12'd1970;
  localparam logic [11:0] LeapsBeforeEpoch = 12'd477;
  localparam logic [12:0] Recip100         = 13'd5243;
  localparam logic [12:0] Hundred          = 13'd100;
  localparam logic [24:0] SecsCommonYear   = 25'd31536000;
  localparam logic [16:0] SecsDay          = 17'd86400;
  localparam logic [11:0] SecsHour         = 12'd3600;
  localparam logic [5:0]  SecsMinute       = 6'd60;

  logic [11:0] yp;
  logic [24:0] prod_p;
  logic [24:0] prod_c;

  logic [11:0] year1;
  logic [11:0] yp1;
  logic [5:0]  q100p1;
  logic [5:0]  q100c1;
  logic [3:0]  month1;
  logic [4:0]  day1;
  logic [4:0]  hour1;
  logic [5:0]  minute1;
  logic [5:0]  second1;

  logic        after_epoch;
  logic [11:0] lp_full;
  logic [9:0]  lp;
  logic [11:0] span;
  logic [11:0] rem100;
  logic        leap;
  logic [4:0]  day_m1;

  logic [36:0] year_s2;
  logic [26:0] lp_s2;
  logic [24:0] mo_s2;
  logic [21:0] day_s2;
  logic [16:0] hour_s2;
  logic [11:0] min_s2;
  logic [5:0]  sec_s2;

  logic [37:0] a3;
  logic [22:0] b3;
  logic [37:0] total4;

  assign yp     = cal_year - 12'd1;
  assign prod_p = 25'(yp) * 25'(Recip100);
  assign prod_c = 25'(cal_year) * 25'(Recip100);

  always_ff @(posedge clk) begin
    year1   <= cal_year;
    yp1     <= yp;
    q100p1  <= prod_p[24:19];
    q100c1  <= prod_c[24:19];
    month1  <= cal_month;
    day1    <= cal_day;
    hour1   <= cal_hour;
    minute1 <= cal_minute;
    second1 <= cal_second;
  end

  always_comb begin
    after_epoch = year1 > EpochYear;
    lp_full = 12'(yp1[11:2]) - 12'(q100p1) + 12'(q100p1[5:2]) - LeapsBeforeEpoch;
    lp      = after_epoch ? lp_full[9:0] : 10'd0;
    span    = after_epoch ? (year1 - EpochYear) : 12'd0;
    rem100  = year1 - 12'(13'(q100c1) * Hundred);
    leap    = (year1[1:0] == 2'd0) && ((rem100 != 12'd0) || (q100c1[1:0] == 2'd0));
    day_m1  = (day1 == 5'd0) ? 5'd0 : day1 - 5'd1;
  end

  always_ff @(posedge clk) begin
    year_s2 <= 37'(span) * 37'(SecsCommonYear);
    lp_s2   <= 27'(lp) * 27'(SecsDay);
    mo_s2   <= cdet_pkg::month_offset(month1, leap);
    day_s2  <= 22'(day_m1) * 22'(SecsDay);
    hour_s2 <= 17'(hour1) * 17'(SecsHour);
    min_s2  <= 12'(minute1) * 12'(SecsMinute);
    sec_s2  <= second1;
  end

  always_ff @(posedge clk) begin
    a3 <= 38'(year_s2) + 38'(lp_s2) + 38'(mo_s2);
    b3 <= 23'(day_s2) + 23'(hour_s2) + 23'(min_s2) + 23'(sec_s2);
  end

  always_ff @(posedge clk) begin
    total4 <= a3 + 38'(b3);
  end

  assign whole_seconds = (total4 > 38'(cdet_pkg::SecsCap)) ? cdet_pkg::SecsCap
                                                           : total4[34:0];

endmodule

FILE: src/cdet_ns_split.sv
module cdet_ns_split (
  input  logic                          clk,
  input  logic [cdet_pkg::UptimeW-1:0]  uptime_ns,
  output logic [cdet_pkg::WholeW-1:0]   whole_seconds,
  output logic [cdet_pkg::NanoW-1:0]    nanoseconds
);

  // One second is 2^9 times an odd factor; the power of two is split off
  // first and the odd factor is divided by a reciprocal with one correction.
  localparam int LowW = 9;
  localparam int MW   = 55;
  localparam int RemW = 22;
  localparam logic [63:0] DivOddFull = 64'd1953125;
  localparam logic [63:0] RecipFull  = (64'd1 << MW) / DivOddFull;
  localparam logic [34:0] Recip      = RecipFull[34:0];
  localparam logic [RemW-1:0] DivOdd = DivOddFull[RemW-1:0];

  logic [MW-1:0] m;

  logic [63:0] pp_ll;
  logic [54:0] pp_hl;
  logic [34:0] pp_lh;
  logic [25:0] pp_hh;
  logic [RemW-1:0] mlow1;
  logic [LowW-1:0] nlow1;

  logic [87:0] x2;
  logic [58:0] y2;
  logic [RemW-1:0] mlow2;
  logic [LowW-1:0] nlow2;

  logic [89:0] p3;
  logic [RemW-1:0] mlow3;
  logic [LowW-1:0] nlow3;

  logic [34:0] q4;
  logic [RemW-1:0] prod4;
  logic [RemW-1:0] mlow4;
  logic [LowW-1:0] nlow4;

  logic [RemW-1:0] diff;
  logic [RemW-1:0] rem;
  logic [34:0] quot;

  assign m = uptime_ns[63:LowW];

  always_ff @(posedge clk) begin
    pp_ll <= 64'(m[31:0]) * 64'(Recip[31:0]);
    pp_hl <= 55'(m[54:32]) * 55'(Recip[31:0]);
    pp_lh <= 35'(m[31:0]) * 35'(Recip[34:32]);
    pp_hh <= 26'(m[54:32]) * 26'(Recip[34:32]);
    mlow1 <= m[RemW-1:0];
    nlow1 <= uptime_ns[LowW-1:0];
  end

  always_ff @(posedge clk) begin
    x2    <= 88'(pp_ll) + 88'({pp_hl, 32'd0});
    y2    <= 59'(pp_lh) + 59'({pp_hh, 32'd0});
    mlow2 <= mlow1;
    nlow2 <= nlow1;
  end

  always_ff @(posedge clk) begin
    p3    <= 90'(x2) + 90'({y2, 32'd0});
    mlow3 <= mlow2;
    nlow3 <= nlow2;
  end

  always_ff @(posedge clk) begin
    q4    <= p3[89:55];
    prod4 <= RemW'(44'(p3[76:55]) * 44'(DivOdd));
    mlow4 <= mlow3;
    nlow4 <= nlow3;
  end

  always_comb begin
    diff = mlow4 - prod4;
    if (diff >= DivOdd) begin
      rem  = diff - DivOdd;
      quot = q4 + 35'd1;
    end else begin
      rem  = diff;
      quot = q4;
    end
  end

  assign whole_seconds = quot;
  assign nanoseconds   = {rem[20:0], nlow4};

endmodule
